@@ sv/olcm_pkg.sv @@
// Shared types, codes and defaults for the offset line/column map.
`timescale 1ns / 1ps

package olcm_pkg;

  // Default sizes
  localparam int STORE_BYTES_DEF   = 65536;
  localparam int INDEX_ENTRIES_DEF = 4096;
  localparam int OFFSET_BITS_DEF   = 32;

  // Register reset
  localparam logic [15:0] RANGE_RESET = 16'd256;

  // Operation codes
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Result status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Divider operand select
  localparam logic [1:0] DIV_SEL_TOTAL = 2'd0;
  localparam logic [1:0] DIV_SEL_NEXT  = 2'd1;
  localparam logic [1:0] DIV_SEL_OFF   = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [31:0] line_number;
    logic [31:0] column;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       div_start;
    logic [1:0] div_sel;
    logic       save_q0;
    logic       ent_load;
    logic       idx_wr;
    logic       byte_wr;
    logic       commit;
    logic       res_full;
    logic       idx_rd;
    logic       res_entry;
    logic       lidx;
    logic       walk_rd;
    logic       hdr;
    logic       pay_rd;
    logic       pay_acc;
    logic       step;
    logic       res_walk;
    logic       emit;
  } olcm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_lookup;
    logic idx_empty;
    logic fits;
    logic div_done;
    logic ent_ok;
    logic ent_zero;
    logic last_byte;
    logic before_start;
    logic walk_end;
    logic pay_more;
    logic hit;
    logic out_free;
  } olcm_stat_t;

endpackage

@@ sv/olcm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module olcm_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [W-1:0]             wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [W-1:0]             rd_data
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/olcm_div.sv @@
// Restoring divider by a 16-bit divisor, one quotient bit per cycle.
`timescale 1ns / 1ps

module olcm_div #(
  parameter int DW = 33
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [15:0]   divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quot
);

  localparam int CW = $clog2(DW + 1);

  logic [15:0]   rem_r, rem_nxt;
  logic [DW-1:0] q_r, q_nxt;
  logic [15:0]   div_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [16:0]   trial;
  logic          qbit;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial   = {rem_r, q_r[DW-1]};
    qbit    = (trial >= {1'b0, div_r});
    rem_nxt = qbit ? 16'(trial - {1'b0, div_r}) : trial[15:0];
    q_nxt   = {q_r[DW-2:0], qbit};
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;

endmodule

@@ sv/olcm_dp.sv @@
// Datapath: stores, index, varint coder, offset walk and result register.
`timescale 1ns / 1ps

module olcm_dp import olcm_pkg::*; #(
  parameter int STORE_BYTES   = STORE_BYTES_DEF,
  parameter int INDEX_ENTRIES = INDEX_ENTRIES_DEF,
  parameter int OFFSET_BITS   = OFFSET_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  logic       cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  olcm_cmd_t  cmd,
  output olcm_stat_t stat,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  localparam int SA_W = $clog2(STORE_BYTES);
  localparam int BU_W = SA_W + 1;
  localparam int IA_W = $clog2(INDEX_ENTRIES);
  localparam int IC_W = IA_W + 1;
  localparam int XW   = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;
  localparam int DW   = XW + 1;
  localparam int IW   = SA_W + 64;

  logic [15:0]            range_r;
  logic [BU_W-1:0]        bytes_used_r;
  logic [IC_W-1:0]        index_count_r;
  logic [OFFSET_BITS-1:0] total_r;
  logic [31:0]            line_next_r;
  logic [31:0]            val_r;
  logic [DW-1:0]          q0_r;
  logic [IC_W-1:0]        ent_cnt_r;
  logic [3:0]             k_r;
  logic [31:0]            off_r;
  logic [BU_W-1:0]        pos_r;
  logic [31:0]            line_r;
  logic [63:0]            len_r;
  logic [3:0]             ones_r;
  out_item_t              res_r;
  logic                   out_valid_r;
  out_item_t              out_data_r;

  logic [15:0]   eff_range;
  logic [DW-1:0] nsum, dividend, quot, newent, room, clip_q;
  logic          div_busy, div_done, off_ok, store_ok, one_byte, out_free;
  logic [2:0]    pay, ncode;
  logic [7:0]    hdr_byte, code_byte, byte_rd;
  logic [1:0]    bidx;
  logic [IW-1:0] idx_rd_data;
  logic [SA_W-1:0] e_pos;
  logic [31:0]   e_start, e_line;
  logic [3:0]    ones;
  logic [7:0]    hmask;

  // Count the leading ones of a header byte
  function automatic logic [3:0] lead_ones(input logic [7:0] b);
    logic [3:0] n;
    logic       run;
    n   = '0;
    run = 1'b1;
    for (int i = 7; i >= 0; i--) begin
      run = run & b[i];
      n   = n + {3'b000, run};
    end
    return n;
  endfunction

  assign eff_range = (range_r == '0) ? 16'd1 : range_r;

  // Append checks: offset room and store room
  assign nsum     = DW'(total_r) + DW'(val_r);
  assign off_ok   = (nsum[DW-1:OFFSET_BITS] == '0);
  assign store_ok = ((BU_W+1)'(bytes_used_r) + (BU_W+1)'(ncode)) <= (BU_W+1)'(STORE_BYTES);

  // Varint code of the appended length
  always_comb begin
    one_byte = (val_r < 32'd128);
    if (val_r < 32'h0000_4000) begin
      pay = 3'd1;
    end else if (val_r < 32'h0020_0000) begin
      pay = 3'd2;
    end else if (val_r < 32'h1000_0000) begin
      pay = 3'd3;
    end else begin
      pay = 3'd4;
    end
    case (pay)
      3'd1:    hdr_byte = {2'b10, val_r[13:8]};
      3'd2:    hdr_byte = {3'b110, val_r[20:16]};
      3'd3:    hdr_byte = {4'b1110, val_r[27:24]};
      default: hdr_byte = 8'hf0;
    endcase
    if (one_byte) begin
      hdr_byte = val_r[7:0];
      ncode    = 3'd1;
    end else begin
      ncode    = pay + 3'd1;
    end
    bidx      = 2'(pay - k_r[2:0]);
    code_byte = (k_r == '0) ? hdr_byte : val_r[{bidx, 3'b000} +: 8];
  end

  // Divider operand select
  always_comb begin
    case (cmd.div_sel)
      DIV_SEL_TOTAL: dividend = DW'(total_r) + DW'(eff_range) - DW'(1);
      DIV_SEL_NEXT:  dividend = nsum + DW'(eff_range) - DW'(1);
      default:       dividend = DW'(val_r);
    endcase
  end

  olcm_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (eff_range),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (quot)
  );

  assign newent = quot - q0_r;
  assign room   = DW'(INDEX_ENTRIES) - DW'(index_count_r);
  assign clip_q = (quot >= DW'(index_count_r)) ? DW'(index_count_r) - DW'(1) : quot;

  olcm_ram #(.W(8), .DEPTH(STORE_BYTES)) u_bytes (
    .clk     (clk),
    .wr_en   (cmd.byte_wr),
    .wr_addr (SA_W'(bytes_used_r + BU_W'(k_r))),
    .wr_data (code_byte),
    .rd_en   (cmd.walk_rd | cmd.pay_rd),
    .rd_addr (SA_W'(pos_r)),
    .rd_data (byte_rd)
  );

  olcm_ram #(.W(IW), .DEPTH(INDEX_ENTRIES)) u_index (
    .clk     (clk),
    .wr_en   (cmd.idx_wr),
    .wr_addr (IA_W'(index_count_r)),
    .wr_data ({SA_W'(bytes_used_r), 32'(total_r), line_next_r}),
    .rd_en   (cmd.idx_rd),
    .rd_addr (IA_W'(clip_q)),
    .rd_data (idx_rd_data)
  );

  assign e_pos   = idx_rd_data[IW-1 -: SA_W];
  assign e_start = idx_rd_data[63:32];
  assign e_line  = idx_rd_data[31:0];

  // Header decode
  assign ones  = lead_ones(byte_rd);
  assign hmask = 8'hff >> (ones + 4'd1);

  assign out_free = !out_valid_r || !out_stall;

  // Status back to the controller
  always_comb begin
    stat.is_lookup    = (in_data.operation == OP_LOOKUP);
    stat.idx_empty    = (index_count_r == '0);
    stat.fits         = off_ok && store_ok;
    stat.div_done     = div_done;
    stat.ent_ok       = (newent <= room);
    stat.ent_zero     = (ent_cnt_r == '0);
    stat.last_byte    = (k_r == 4'(ncode) - 4'd1);
    stat.before_start = (off_r < e_start);
    stat.walk_end     = (pos_r >= bytes_used_r);
    stat.pay_more     = (k_r < ones_r) && (pos_r < bytes_used_r);
    stat.hit          = ({32'd0, off_r} < len_r);
    stat.out_free     = out_free;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r <= RANGE_RESET;
    end else if (cfg_wr_en) begin
      range_r <= cfg_wr_data;
    end
  end

  // Persistent store state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_used_r  <= '0;
      index_count_r <= '0;
      total_r       <= '0;
      line_next_r   <= 32'd1;
    end else begin
      if (cmd.idx_wr) begin
        index_count_r <= index_count_r + 1'b1;
      end
      if (cmd.commit) begin
        bytes_used_r <= bytes_used_r + BU_W'(ncode);
        total_r      <= nsum[OFFSET_BITS-1:0];
        line_next_r  <= line_next_r + 32'd1;
      end
    end
  end

  // Per-transaction working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r  <= in_data.value;
      off_r  <= in_data.value;
      pos_r  <= '0;
      line_r <= 32'd1;
    end
    if (cmd.save_q0) begin
      q0_r <= quot;
    end
    if (cmd.ent_load) begin
      ent_cnt_r <= IC_W'(newent);
      k_r       <= '0;
    end
    if (cmd.idx_wr) begin
      ent_cnt_r <= ent_cnt_r - 1'b1;
    end
    if (cmd.byte_wr) begin
      k_r <= k_r + 4'd1;
    end
    if (cmd.lidx) begin
      off_r  <= off_r - e_start;
      pos_r  <= BU_W'(e_pos);
      line_r <= e_line;
    end
    if (cmd.hdr) begin
      len_r  <= 64'(byte_rd & hmask);
      ones_r <= ones;
      pos_r  <= pos_r + 1'b1;
      k_r    <= '0;
    end
    if (cmd.pay_acc) begin
      len_r <= {len_r[55:0], byte_rd};
      pos_r <= pos_r + 1'b1;
      k_r   <= k_r + 4'd1;
    end
    if (cmd.step) begin
      off_r  <= off_r - len_r[31:0];
      line_r <= line_r + 32'd1;
    end
  end

  // Result capture
  always_ff @(posedge clk) begin
    if (cmd.res_full) begin
      res_r <= '{status: STATUS_FULL, line_number: line_next_r, column: 32'd0};
    end else if (cmd.commit) begin
      res_r <= '{status: STATUS_OK, line_number: line_next_r, column: 32'd0};
    end else if (cmd.res_entry) begin
      res_r <= '{status: STATUS_OK, line_number: e_line, column: 32'd0};
    end else if (cmd.res_walk) begin
      res_r <= '{status: STATUS_OK, line_number: line_r, column: off_r};
    end
  end

  // Output register: hold until the transaction is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    index_count_r <= IC_W'(INDEX_ENTRIES))
    else $error("index count past capacity");
  a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_used_r <= BU_W'(STORE_BYTES))
    else $error("byte store past capacity");
  a_idx_wr_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.idx_wr |-> (index_count_r < IC_W'(INDEX_ENTRIES)))
    else $error("index write with no room");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free)
    else $error("result emitted over a waiting transaction");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy)
    else $error("divider restarted while busy");
`endif

endmodule

@@ sv/olcm_ctrl.sv @@
// Controller state machine sequencing appends and lookups.
`timescale 1ns / 1ps

module olcm_ctrl import olcm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  olcm_stat_t stat,
  output olcm_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_DIV0  = 4'd2;
  localparam logic [3:0] S_DIV1  = 4'd3;
  localparam logic [3:0] S_IDX   = 4'd4;
  localparam logic [3:0] S_BYTE  = 4'd5;
  localparam logic [3:0] S_LDIV  = 4'd6;
  localparam logic [3:0] S_LDIVW = 4'd7;
  localparam logic [3:0] S_LIDX  = 4'd8;
  localparam logic [3:0] S_WALK  = 4'd9;
  localparam logic [3:0] S_HDR   = 4'd10;
  localparam logic [3:0] S_PAY   = 4'd11;
  localparam logic [3:0] S_PAYW  = 4'd12;
  localparam logic [3:0] S_CMP   = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic       accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.div_sel = DIV_SEL_OFF;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (!stat.is_lookup) begin
            state_nxt = S_CHECK;
          end else if (stat.idx_empty) begin
            state_nxt = S_WALK;
          end else begin
            state_nxt = S_LDIV;
          end
        end
      end
      S_CHECK: begin
        if (stat.fits) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SEL_TOTAL;
          state_nxt     = S_DIV0;
        end else begin
          cmd.res_full = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_DIV0: begin
        if (stat.div_done) begin
          cmd.save_q0   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SEL_NEXT;
          state_nxt     = S_DIV1;
        end
      end
      S_DIV1: begin
        if (stat.div_done) begin
          if (stat.ent_ok) begin
            cmd.ent_load = 1'b1;
            state_nxt    = S_IDX;
          end else begin
            cmd.res_full = 1'b1;
            state_nxt    = S_DONE;
          end
        end
      end
      S_IDX: begin
        if (stat.ent_zero) begin
          state_nxt = S_BYTE;
        end else begin
          cmd.idx_wr = 1'b1;
        end
      end
      S_BYTE: begin
        cmd.byte_wr = 1'b1;
        if (stat.last_byte) begin
          cmd.commit = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_LDIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_LDIVW;
      end
      S_LDIVW: begin
        if (stat.div_done) begin
          cmd.idx_rd = 1'b1;
          state_nxt  = S_LIDX;
        end
      end
      S_LIDX: begin
        if (stat.before_start) begin
          cmd.res_entry = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          cmd.lidx  = 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (stat.walk_end) begin
          cmd.res_walk = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.walk_rd = 1'b1;
          state_nxt   = S_HDR;
        end
      end
      S_HDR: begin
        cmd.hdr   = 1'b1;
        state_nxt = S_PAY;
      end
      S_PAY: begin
        if (stat.pay_more) begin
          cmd.pay_rd = 1'b1;
          state_nxt  = S_PAYW;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_PAYW: begin
        cmd.pay_acc = 1'b1;
        state_nxt   = S_PAY;
      end
      S_CMP: begin
        if (stat.hit) begin
          cmd.res_walk = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ sv/offset_line_column_map_unit.sv @@
// Top level of the offset line/column map: controller plus datapath.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall   | in_data (operation, value)
//  out     | output    | out_valid / out_stall | out_data (status, line_number, column)
//  cfg     | input     | cfg_wr_en             | cfg_wr_data (range_per_index)
//
// One transaction at a time; each division is bit-serial over D = max(OFFSET_BITS,32)+1 bits.
// Append: two divisions, then the E new index entries and the B code bytes are
// written in turn; an offset or store refusal skips straight to the result.
// Lookup: a division and an index read (skipped with an empty index), then a walk
// that reads each length header and its payload bytes until a hit or the store end.
// Reset is synchronous and clears counters, range and control only; stores need no
// clearing pass. A waiting result does not block taking the next transaction.
`timescale 1ns / 1ps

module offset_line_column_map_unit import olcm_pkg::*; #(
  parameter int STORE_BYTES   = STORE_BYTES_DEF,
  parameter int INDEX_ENTRIES = INDEX_ENTRIES_DEF,
  parameter int OFFSET_BITS   = OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  olcm_cmd_t  cmd;
  olcm_stat_t stat;

  olcm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  olcm_dp #(
    .STORE_BYTES   (STORE_BYTES),
    .INDEX_ENTRIES (INDEX_ENTRIES),
    .OFFSET_BITS   (OFFSET_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
